// ----- rtl/arpc_pkg.sv -----
package arpc_pkg;

	localparam int CACHE_ENTRIES = 4;
	localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

	// The queue depth must be a power of two so that the pointers wrap on their own.
	localparam int Q_DEPTH = 2;
	localparam int QP_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QCNT_W = $clog2(Q_DEPTH + 1);

	localparam int IP_W = 32;
	localparam int MAC_W = 48;
	localparam int OPC_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 48;

	localparam logic OP_ARP = 1'b0;
	localparam logic OP_RESOLVE = 1'b1;

	localparam logic [OPC_W-1:0] OPC_REQUEST = 16'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY_IP = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 2'd3;

	typedef enum logic [1:0] {
		ACT_REPLY = 2'd0,
		ACT_HIT = 2'd1,
		ACT_MISS = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// One classified job: for an ARP beat the key is the sender IP, for a
	// resolve beat it is the next hop already chosen by the front.
	typedef struct packed {
		logic op;
		logic reply;
		logic [IP_W-1:0] key_ip;
		logic [MAC_W-1:0] mac;
	} job_t;

endpackage

// ----- rtl/arp_cache_resolver.sv -----
// The back end takes one item at a time: it walks 1 to CACHE_ENTRIES cache
// entries, one entry per cycle, stopping at a match or the last entry, and
// pops the next item only after committing the result of the last one.
// Two items may wait in the queue between the front and the back end.
// Reset (arst_n low) empties the queue, invalidates every cache entry and
// clears the address registers to zero.
module arp_cache_resolver
	import arpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  operation,
	input  logic [OPC_W-1:0]      arp_opcode,
	input  logic [IP_W-1:0]       sender_ip,
	input  logic [MAC_W-1:0]      sender_mac,
	input  logic [IP_W-1:0]       target_addr,
	input  logic [IP_W-1:0]       dest_ip,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            action,
	output logic [MAC_W-1:0]      mac_out,
	output logic [IP_W-1:0]       ip_out
);

	logic push;
	job_t push_job;
	logic q_full;
	logic pop;
	logic q_valid;
	job_t q_job;

	arpc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.arp_opcode  (arp_opcode),
		.sender_ip   (sender_ip),
		.sender_mac  (sender_mac),
		.target_addr (target_addr),
		.dest_ip     (dest_ip),
		.push        (push),
		.push_job    (push_job),
		.q_full      (q_full)
	);

	arpc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_job    (q_job)
	);

	arpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_job     (q_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.action    (action),
		.mac_out   (mac_out),
		.ip_out    (ip_out)
	);

endmodule

// ----- rtl/arpc_front.sv -----
module arpc_front
	import arpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  operation,
	input  logic [OPC_W-1:0]      arp_opcode,
	input  logic [IP_W-1:0]       sender_ip,
	input  logic [MAC_W-1:0]      sender_mac,
	input  logic [IP_W-1:0]       target_addr,
	input  logic [IP_W-1:0]       dest_ip,
	output logic                  push,
	output job_t                  push_job,
	input  logic                  q_full
);

	logic [IP_W-1:0] own_ip_q;
	logic [IP_W-1:0] subnet_mask_q;
	logic [IP_W-1:0] gateway_ip_q;
	logic            off_subnet;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q <= '0;
			subnet_mask_q <= '0;
			gateway_ip_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OWN_IP:      own_ip_q <= cfg_data[IP_W-1:0];
				CFG_SUBNET_MASK: subnet_mask_q <= cfg_data[IP_W-1:0];
				CFG_GATEWAY_IP:  gateway_ip_q <= cfg_data[IP_W-1:0];
				// The station MAC is accepted but no result depends on it.
				CFG_OWN_MAC:     ;
				default:         ;
			endcase
		end
	end

	assign off_subnet = (dest_ip & subnet_mask_q) != (own_ip_q & subnet_mask_q);

	assign in_ready = !q_full;
	assign push = in_valid && !q_full;

	always_comb begin
		push_job.op = operation;
		if (operation == OP_ARP) begin
			push_job.reply = (arp_opcode == OPC_REQUEST) && (target_addr == own_ip_q);
			push_job.key_ip = sender_ip;
			push_job.mac = sender_mac;
		end else begin
			push_job.reply = 1'b0;
			push_job.key_ip = off_subnet ? gateway_ip_q : dest_ip;
			push_job.mac = '0;
		end
	end

endmodule

// ----- rtl/arpc_queue.sv -----
module arpc_queue
	import arpc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic q_valid,
	output job_t q_job
);

	job_t              slot_q [Q_DEPTH];
	logic [QP_W-1:0]   wr_ptr_q;
	logic [QP_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign full = count_q == QCNT_W'(Q_DEPTH);
	assign q_valid = count_q != '0;
	assign q_job = slot_q[rd_ptr_q];
	assign do_pop = pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/arpc_back.sv -----
module arpc_back
	import arpc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  job_t              q_job,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        action,
	output logic [MAC_W-1:0]  mac_out,
	output logic [IP_W-1:0]   ip_out
);

	state_t            state_q;
	state_t            state_d;
	job_t              job_q;
	logic [IDX_W-1:0]  idx_q;
	logic              found_q;
	logic [IP_W-1:0]   entry_ip_q [CACHE_ENTRIES];
	logic [MAC_W-1:0]  entry_mac_q [CACHE_ENTRIES];
	logic [CACHE_ENTRIES-1:0] entry_valid_q;
	logic              match;
	logic              last_idx;
	logic              scan_step;
	logic              commit;
	logic [IDX_W-1:0]  wr_idx;
	action_t           action_q;

	// Learning stops at the first free slot or at a slot holding the same IP;
	// lookup stops at the first valid entry holding the IP.
	always_comb begin
		if (job_q.op == OP_ARP) begin
			match = !entry_valid_q[idx_q] || (entry_ip_q[idx_q] == job_q.key_ip);
		end else begin
			match = entry_valid_q[idx_q] && (entry_ip_q[idx_q] == job_q.key_ip);
		end
	end

	assign last_idx = idx_q == IDX_W'(CACHE_ENTRIES - 1);
	assign wr_idx = found_q ? idx_q : '0;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (q_valid) state_d = ST_SCAN;
			ST_SCAN: if (match || last_idx) state_d = ST_DONE;
			ST_DONE: if (!out_valid || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		scan_step = 1'b0;
		commit = 1'b0;
		unique case (state_q)
			ST_IDLE: pop = q_valid;
			ST_SCAN: scan_step = 1'b1;
			ST_DONE: commit = !out_valid || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			entry_valid_q <= '0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (commit && job_q.op == OP_ARP) begin
				entry_valid_q[wr_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_job;
			idx_q <= '0;
			found_q <= 1'b0;
		end
		if (scan_step) begin
			found_q <= match;
			if (!match && !last_idx) begin
				idx_q <= idx_q + 1'b1;
			end
		end
		if (commit) begin
			if (job_q.op == OP_ARP) begin
				entry_ip_q[wr_idx] <= job_q.key_ip;
				entry_mac_q[wr_idx] <= job_q.mac;
				action_q <= job_q.reply ? ACT_REPLY : ACT_NONE;
				mac_out <= job_q.reply ? job_q.mac : '0;
				ip_out <= job_q.reply ? job_q.key_ip : '0;
			end else begin
				action_q <= found_q ? ACT_HIT : ACT_MISS;
				mac_out <= found_q ? entry_mac_q[idx_q] : '0;
				ip_out <= job_q.key_ip;
			end
		end
	end

	assign action = action_q;

endmodule

// ----- rtl/arpc_checker.sv -----
module arpc_checker
	import arpc_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic [1:0]       action,
	input logic [MAC_W-1:0] mac_out,
	input logic [IP_W-1:0]  ip_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(action) && $stable(mac_out)
			&& $stable(ip_out))
		else $error("result beat changed while stalled");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == ACT_NONE |-> mac_out == '0 && ip_out == '0)
		else $error("empty result carries an address");

	a_miss_no_mac: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == ACT_MISS |-> mac_out == '0)
		else $error("miss result carries a MAC");

	// The flops reset asynchronously; the check looks at out_valid in the cycle
	// after each clock edge that samples reset low.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result offered during reset");

endmodule

bind arp_cache_resolver arpc_checker u_arpc_checker (.*);
